[rtl/cda_pkg.sv]
// Package for the calendar date adder: command and result words, field widths,
// command, status and register codes. No dependencies.
`default_nettype none

package cda_pkg;

  localparam int unsigned DAY_W     = 5;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned YEAR_W    = 12;
  localparam int unsigned AMT_W     = 16;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_DAYS   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_MONTHS = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INVALID  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_DATE  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_YEAR = 2'd1;

  localparam logic [YEAR_W-1:0]  YEAR_TOP        = 12'd4095;
  localparam logic [YEAR_W-1:0]  MIN_YEAR_RST    = 12'd1900;
  localparam logic [YEAR_W-1:0]  MAX_YEAR_RST    = 12'd2100;
  localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB       = 4'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [DAY_W-1:0]   load_day;
    logic [MONTH_W-1:0] load_month;
    logic [YEAR_W-1:0]  load_year;
    logic [AMT_W-1:0]   amount;
  } cmd_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [DAY_W-1:0]   cur_day;
    logic [MONTH_W-1:0] cur_month;
    logic [YEAR_W-1:0]  cur_year;
    logic               date_held;
  } result_word_t;

endpackage

`default_nettype wire

[rtl/cda_month_len.sv]
// Month length unit: days in a month of a given Gregorian year, leap years included.
// Uses cda_pkg for field widths.
`default_nettype none

module cda_month_len
  import cda_pkg::*;
(
  input  logic [MONTH_W-1:0] month_i,
  input  logic [YEAR_W-1:0]  year_i,
  output logic [DAY_W-1:0]   len_o
);

  // 41 is the inverse of 25 mod 1024: x*41 mod 1024 <= 40 iff 25 divides x
  localparam logic [YEAR_W-3:0] Inv25   = 10'd41;
  localparam logic [YEAR_W-3:0] Div25Lim = 10'd40;

  logic [YEAR_W-3:0] quarter;
  logic [YEAR_W-3:0] prod;
  logic              div25;
  logic              leap;

  assign quarter = year_i[YEAR_W-1:2];
  assign prod    = quarter * Inv25;
  assign div25   = (prod <= Div25Lim);
  // divisible by 4; a century only when also divisible by 400 (year mod 16 == 0)
  assign leap    = (year_i[1:0] == 2'b00) && (!div25 || (year_i[3:0] == 4'h0));

  always_comb begin
    unique case (month_i)
      MONTH_FEB:                   len_o = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:     len_o = 5'd30;
      default:                     len_o = 5'd31;
    endcase
  end

endmodule

`default_nettype wire

[rtl/calendar_date_adder.sv]
// Calendar date adder: one held Gregorian date with load, add days, add months.
// Steps from accept to the done strobe: load S_LOAD, S_FIN; add on an empty register or
// unused command S_FIN; add days S_DAYS, one month per pass of the month length unit,
// then S_FIN; add months S_DIV, S_DREM, S_MYEAR, S_MFIN, S_FIN (no S_MFIN on overflow).
// busy_o drops in the done cycle, so the next word may be accepted then; one at a time.
// Reset clears the held date and sets the year limits to 1900 and 2100.
`default_nettype none

module calendar_date_adder
  import cda_pkg::*;
#(
  parameter int unsigned AMOUNT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  cmd_word_t            cmd_i,
  output logic                 done_o,
  output result_word_t         result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [YEAR_W-1:0]    cfg_data_i
);

  localparam int unsigned EffBits = (AMOUNT_BITS < AMT_W) ? AMOUNT_BITS : AMT_W;
  localparam int unsigned DivW    = EffBits + 1;
  localparam int unsigned QpW     = DivW + 14;
  localparam int unsigned YsumW   = ((DivW > YEAR_W) ? DivW : YEAR_W) + 1;
  localparam logic [15:0] Recip3  = 16'hAAAB;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_DAYS  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MYEAR = 3'd4;
  localparam logic [2:0] S_MFIN  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_DREM  = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [YEAR_W-1:0]   min_year_q, max_year_q;
  logic                held_valid_q, held_valid_d;
  logic [DAY_W-1:0]    held_day_q, held_day_d;
  logic [MONTH_W-1:0]  held_month_q, held_month_d;
  logic [YEAR_W-1:0]   held_year_q, held_year_d;
  logic [STAT_W-1:0]   st_q, st_d;
  logic [DAY_W-1:0]    ld_day_q, ld_day_d;
  logic [MONTH_W-1:0]  ld_month_q, ld_month_d;
  logic [YEAR_W-1:0]   ld_year_q, ld_year_d;
  logic [DivW-1:0]     acc_q, acc_d;
  logic [DivW-1:0]     div_q, div_d;
  logic [MONTH_W-1:0]  rem_q, rem_d;
  logic [MONTH_W-1:0]  wm_q, wm_d;
  logic [YEAR_W-1:0]   wy_q, wy_d;
  logic                done_q, done_d;
  result_word_t        result_q, result_d;

  logic [MONTH_W-1:0]  ml_month;
  logic [YEAR_W-1:0]   ml_year;
  logic [DAY_W-1:0]    ml_len;
  logic [DivW-1:0]     amt_eff;
  logic                ld_ok;
  logic [QpW-1:0]      qprod;
  logic [DivW-1:0]     quot;
  logic [DivW-1:0]     rem_full;
  logic [YsumW-1:0]    ysum;

  // shared month length unit: load check, day walk, final clamp
  assign ml_month = (state_q == S_LOAD) ? ld_month_q : wm_q;
  assign ml_year  = (state_q == S_LOAD) ? ld_year_q  : wy_q;

  cda_month_len u_month_len (
    .month_i (ml_month),
    .year_i  (ml_year),
    .len_o   (ml_len)
  );

  assign amt_eff = DivW'(cmd_i.amount[EffBits-1:0]);

  assign ld_ok = (ld_year_q >= min_year_q) && (ld_year_q <= max_year_q) &&
                 (ld_month_q != '0) && (ld_month_q <= MONTHS_PER_YEAR) &&
                 (ld_day_q != '0) && (ld_day_q <= ml_len);

  // divide by 12: drop two bits, then multiply by the reciprocal of 3 (exact below 2^17)
  assign qprod    = QpW'(div_q[DivW-1:2]) * QpW'(Recip3);
  assign quot     = DivW'(qprod[QpW-1:17]);
  assign rem_full = div_q - {acc_q[DivW-4:0], 3'b000} - {acc_q[DivW-3:0], 2'b00};
  assign ysum     = YsumW'(held_year_q) + YsumW'(acc_q);

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign result_o    = result_q;

  always_comb begin
    state_d      = state_q;
    held_valid_d = held_valid_q;
    held_day_d   = held_day_q;
    held_month_d = held_month_q;
    held_year_d  = held_year_q;
    st_d         = st_q;
    ld_day_d     = ld_day_q;
    ld_month_d   = ld_month_q;
    ld_year_d    = ld_year_q;
    acc_d        = acc_q;
    div_d        = div_q;
    rem_d        = rem_q;
    wm_d         = wm_q;
    wy_d         = wy_q;
    done_d       = 1'b0;
    result_d     = result_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ld_day_d   = cmd_i.load_day;
          ld_month_d = cmd_i.load_month;
          ld_year_d  = cmd_i.load_year;
          acc_d      = DivW'(held_day_q) + amt_eff;
          div_d      = DivW'(held_month_q - 4'd1) + amt_eff;
          rem_d      = '0;
          wm_d       = held_month_q;
          wy_d       = held_year_q;
          st_d       = STAT_OK;
          priority if (cmd_i.command == CMD_LOAD) begin
            state_d = S_LOAD;
          end else if ((cmd_i.command == CMD_ADD_DAYS || cmd_i.command == CMD_ADD_MONTHS)
                       && !held_valid_q) begin
            st_d    = STAT_NO_DATE;
            state_d = S_FIN;
          end else if (cmd_i.command == CMD_ADD_DAYS) begin
            state_d = S_DAYS;
          end else if (cmd_i.command == CMD_ADD_MONTHS) begin
            state_d = S_DIV;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_LOAD: begin
        if (ld_ok) begin
          held_valid_d = 1'b1;
          held_day_d   = ld_day_q;
          held_month_d = ld_month_q;
          held_year_d  = ld_year_q;
        end else begin
          st_d = STAT_INVALID;
        end
        state_d = S_FIN;
      end
      S_DAYS: begin
        if (acc_q > DivW'(ml_len)) begin
          acc_d = acc_q - DivW'(ml_len);
          if (wm_q == MONTHS_PER_YEAR) begin
            wm_d = 4'd1;
            if (wy_q == YEAR_TOP) begin
              st_d    = STAT_OVERFLOW;
              state_d = S_FIN;
            end else begin
              wy_d = wy_q + 12'd1;
            end
          end else begin
            wm_d = wm_q + 4'd1;
          end
        end else begin
          held_day_d   = acc_q[DAY_W-1:0];
          held_month_d = wm_q;
          held_year_d  = wy_q;
          state_d      = S_FIN;
        end
      end
      S_DIV: begin
        acc_d   = quot;
        state_d = S_DREM;
      end
      S_DREM: begin
        rem_d   = rem_full[MONTH_W-1:0];
        state_d = S_MYEAR;
      end
      S_MYEAR: begin
        if (ysum > YsumW'(YEAR_TOP)) begin
          st_d    = STAT_OVERFLOW;
          state_d = S_FIN;
        end else begin
          wy_d    = ysum[YEAR_W-1:0];
          wm_d    = rem_q + 4'd1;
          state_d = S_MFIN;
        end
      end
      S_MFIN: begin
        held_month_d = wm_q;
        held_year_d  = wy_q;
        if (held_day_q > ml_len) begin
          held_day_d = ml_len;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        done_d             = 1'b1;
        result_d.status    = st_q;
        result_d.date_held = held_valid_q;
        if (held_valid_q) begin
          result_d.cur_day   = held_day_q;
          result_d.cur_month = held_month_q;
          result_d.cur_year  = held_year_q;
        end else begin
          result_d.cur_day   = '0;
          result_d.cur_month = '0;
          result_d.cur_year  = '0;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      min_year_q   <= MIN_YEAR_RST;
      max_year_q   <= MAX_YEAR_RST;
      held_valid_q <= 1'b0;
      held_day_q   <= '0;
      held_month_q <= '0;
      held_year_q  <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      held_valid_q <= held_valid_d;
      held_day_q   <= held_day_d;
      held_month_q <= held_month_d;
      held_year_q  <= held_year_d;
      done_q       <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_MIN_YEAR) begin
          min_year_q <= cfg_data_i;
        end
        if (cfg_index_i == CFG_MAX_YEAR) begin
          max_year_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q       <= st_d;
    ld_day_q   <= ld_day_d;
    ld_month_q <= ld_month_d;
    ld_year_q  <= ld_year_d;
    acc_q      <= acc_d;
    div_q      <= div_d;
    rem_q      <= rem_d;
    wm_q       <= wm_d;
    wy_q       <= wy_d;
    result_q   <= result_d;
  end

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while sequencer busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not start sequencer");

  a_held_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(held_valid_q))
    else $error("held date lost");

  a_held_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid_q |-> (held_month_q != '0 && held_month_q <= MONTHS_PER_YEAR))
    else $error("held month out of range");
`endif

endmodule

`default_nettype wire
